>>> design/tps_pkg.sv
// Shared types, register codes and constants for the triangle plane slicer.
`timescale 1ns / 1ps
`default_nettype none
package tps_pkg;

	// input transaction: three vertices, Q16.16
	typedef struct packed {
		logic signed [31:0] v0_x;
		logic signed [31:0] v0_y;
		logic signed [31:0] v0_z;
		logic signed [31:0] v1_x;
		logic signed [31:0] v1_y;
		logic signed [31:0] v1_z;
		logic signed [31:0] v2_x;
		logic signed [31:0] v2_y;
		logic signed [31:0] v2_z;
	} tri_t;

	// output transaction: segment end points, Q16.16
	typedef struct packed {
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] start_z;
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
		logic signed [31:0] end_z;
	} seg_t;

	// register map
	typedef enum logic [2:0] {
		REG_PLANE_A,
		REG_PLANE_B,
		REG_PLANE_C,
		REG_PLANE_D,
		REG_EPSILON
	} cfg_reg_t;

	localparam logic signed [31:0] PLANE_C_RESET = 32'sd1073741824;

	// widths: distance Q20.32 fits in 52 bits, edge sum in 53
	localparam int DIST_W  = 52;
	localparam int DEN_W   = DIST_W + 1;
	localparam int SH_W    = $clog2(DEN_W - 32 + 1);
	localparam int T_W     = 31;
	localparam int DIV_STEPS = T_W;

	// stage counts of each part
	localparam int DIST_STAGES  = 2;
	localparam int EDGE_STAGES  = 2;
	localparam int MERGE_STAGES = 7;
	localparam int LATENCY = DIST_STAGES + EDGE_STAGES + DIV_STEPS + MERGE_STAGES;

	typedef logic signed [DIST_W-1:0] dist_t;

	// point as x,y,z at index 0,1,2
	typedef logic [2:0][31:0] pt_t;

	// edge end vertices, edges in order 01, 12, 02
	localparam logic [1:0] EDGE_LO [3] = '{2'd0, 2'd1, 2'd0};
	localparam logic [1:0] EDGE_HI [3] = '{2'd1, 2'd2, 2'd2};

	// per-triangle context carried alongside the divider
	typedef struct packed {
		tri_t       verts;
		logic [2:0] tested;
		logic [2:0] on;
	} ctx_t;

	function automatic pt_t vtx(tri_t t, logic [1:0] k);
		pt_t p;
		case (k)
			2'd0: begin
				p[0] = t.v0_x; p[1] = t.v0_y; p[2] = t.v0_z;
			end
			2'd1: begin
				p[0] = t.v1_x; p[1] = t.v1_y; p[2] = t.v1_z;
			end
			default: begin
				p[0] = t.v2_x; p[1] = t.v2_y; p[2] = t.v2_z;
			end
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

>>> design/triangle_plane_slice.sv
// Top level of the triangle plane slicer: registers, pipeline and handshake.
//
// Channel  Dir  Handshake            Payload
// cfg      in   cfg_we               cfg_index, cfg_data
// tri      in   tri_valid/tri_ready  tri_data (three Q16.16 vertices)
// seg      out  seg_valid/seg_ready  seg_data (two Q16.16 end points)
//
// One triangle per cycle while no segment waits at the output; the divider has 31 stages.
// A triangle yields zero or one segment; triangles with none raise no seg_valid.
// Reset clears the plane registers to z = 0 and empties the pipeline.
// While a segment waits at the output, the whole pipeline holds.
`timescale 1ns / 1ps
`default_nettype none
module triangle_plane_slice (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_data,
	input  logic          tri_valid,
	output logic          tri_ready,
	input  tps_pkg::tri_t tri_data,
	output logic          seg_valid,
	input  logic          seg_ready,
	output tps_pkg::seg_t seg_data
);
	import tps_pkg::*;

	logic signed [31:0] plane_a_q, plane_b_q, plane_c_q, plane_d_q;
	logic [15:0]        eps_q;

	logic               en;
	logic [LATENCY-1:0] vld_s;

	dist_t       dist_w [3];
	tri_t        verts_w;
	logic [31:0] num_w [3];
	logic [31:0] den_w [3];
	ctx_t        ctx_w;
	logic [T_W-1:0] t_w [3];
	ctx_t        ctx_d [DIV_STEPS];
	logic        ok_w;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_a_q <= '0;
			plane_b_q <= '0;
			plane_c_q <= PLANE_C_RESET;
			plane_d_q <= '0;
			eps_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PLANE_A: plane_a_q <= cfg_data;
				REG_PLANE_B: plane_b_q <= cfg_data;
				REG_PLANE_C: plane_c_q <= cfg_data;
				REG_PLANE_D: plane_d_q <= cfg_data;
				REG_EPSILON: eps_q     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// pipeline advances unless a segment is held at the output
	assign en        = !seg_valid || seg_ready;
	assign tri_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LATENCY-2:0], tri_valid};
		end
	end

	tps_dist u_dist (
		.clk      (clk),
		.en       (en),
		.verts    (tri_data),
		.plane_a  (plane_a_q),
		.plane_b  (plane_b_q),
		.plane_c  (plane_c_q),
		.plane_d  (plane_d_q),
		.dists    (dist_w),
		.verts_out(verts_w)
	);

	tps_edge u_edge (
		.clk  (clk),
		.en   (en),
		.dists(dist_w),
		.verts(verts_w),
		.eps  (eps_q),
		.num_n(num_w),
		.den_n(den_w),
		.ctx  (ctx_w)
	);

	for (genvar k = 0; k < 3; k++) begin : g_div
		tps_div u_div (
			.clk(clk),
			.en (en),
			.num(num_w[k]),
			.den(den_w[k]),
			.q  (t_w[k])
		);
	end

	// context delay line matching the divider depth
	always_ff @(posedge clk) begin
		if (en) begin
			ctx_d[0] <= ctx_w;
			for (int k = 1; k < DIV_STEPS; k++) ctx_d[k] <= ctx_d[k-1];
		end
	end

	tps_merge u_merge (
		.clk(clk),
		.en (en),
		.ctx(ctx_d[DIV_STEPS-1]),
		.t  (t_w),
		.eps(eps_q),
		.seg(seg_data),
		.ok (ok_w)
	);

	assign seg_valid = vld_s[LATENCY-1] & ok_w;

endmodule
`default_nettype wire

>>> design/tps_dist.sv
// Signed vertex-to-plane distances over two pipeline stages.
`timescale 1ns / 1ps
`default_nettype none
module tps_dist (
	input  logic               clk,
	input  logic               en,
	input  tps_pkg::tri_t      verts,
	input  logic signed [31:0] plane_a,
	input  logic signed [31:0] plane_b,
	input  logic signed [31:0] plane_c,
	input  logic signed [31:0] plane_d,
	output tps_pkg::dist_t     dists [3],
	output tps_pkg::tri_t      verts_out
);
	import tps_pkg::*;

	pt_t                vp_c [3];
	logic signed [63:0] prod_s1 [3][3];
	tri_t               verts_s1;
	dist_t              dist_c [3];
	dist_t              dist_s2 [3];
	tri_t               verts_s2;
	dist_t              doff_c;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			vp_c[k] = vtx(verts, 2'(k));
		end
	end

	// stage 1: nine coefficient by coordinate products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				prod_s1[k][0] <= plane_a * $signed(vp_c[k][0]);
				prod_s1[k][1] <= plane_b * $signed(vp_c[k][1]);
				prod_s1[k][2] <= plane_c * $signed(vp_c[k][2]);
			end
			verts_s1 <= verts;
		end
	end

	// stage 2: floor-scaled products plus offset, Q20.32
	always_comb begin
		doff_c = $signed({{(DIST_W-48){plane_d[31]}}, plane_d, 16'b0});
		for (int k = 0; k < 3; k++) begin
			dist_c[k] = DIST_W'(prod_s1[k][0] >>> 14) + DIST_W'(prod_s1[k][1] >>> 14)
				+ DIST_W'(prod_s1[k][2] >>> 14) + doff_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dist_s2  <= dist_c;
			verts_s2 <= verts_s1;
		end
	end

	assign dists     = dist_s2;
	assign verts_out = verts_s2;

endmodule
`default_nettype wire

>>> design/tps_edge.sv
// Edge crossing tests and divisor normalisation, two pipeline stages.
`timescale 1ns / 1ps
`default_nettype none
module tps_edge (
	input  logic           clk,
	input  logic           en,
	input  tps_pkg::dist_t dists [3],
	input  tps_pkg::tri_t  verts,
	input  logic [15:0]    eps,
	output logic [31:0]    num_n [3],
	output logic [31:0]    den_n [3],
	output tps_pkg::ctx_t  ctx
);
	import tps_pkg::*;

	dist_t             e_c;
	logic [2:0]        on_c;
	logic [2:0]        tested_c;
	logic [DIST_W-1:0] mag_c [3];
	logic [DEN_W-1:0]  den_c [3];

	logic [DIST_W-1:0] num_s3 [3];
	logic [DEN_W-1:0]  den_s3 [3];
	logic [2:0]        tested_s3;
	logic [2:0]        on_s3;
	tri_t              verts_s3;

	logic [SH_W-1:0]   sh_c [3];
	logic [31:0]       num_s4 [3];
	logic [31:0]       den_s4 [3];
	ctx_t              ctx_s4;

	// stage 3: on-plane flags, edge tests, magnitudes
	always_comb begin
		e_c = $signed({{(DIST_W-32){1'b0}}, eps, 16'b0});
		for (int v = 0; v < 3; v++) begin
			on_c[v]  = (dists[v] <= e_c) && (dists[v] >= -e_c);
			mag_c[v] = dists[v][DIST_W-1] ? DIST_W'(-dists[v]) : DIST_W'(dists[v]);
		end
		for (int k = 0; k < 3; k++) begin
			tested_c[k] = ((dists[EDGE_LO[k]] <= e_c) && (dists[EDGE_HI[k]] >= -e_c))
				|| ((dists[EDGE_LO[k]] >= -e_c) && (dists[EDGE_HI[k]] <= e_c));
			den_c[k] = {1'b0, mag_c[EDGE_LO[k]]} + {1'b0, mag_c[EDGE_HI[k]]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				num_s3[k] <= mag_c[EDGE_LO[k]];
				den_s3[k] <= den_c[k];
			end
			tested_s3 <= tested_c;
			on_s3     <= on_c;
			verts_s3  <= verts;
		end
	end

	// stage 4: shift both operands until the divisor fits 32 bits
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sh_c[k] = '0;
			for (int b = 0; b < DEN_W - 32; b++) begin
				if (den_s3[k][32+b]) sh_c[k] = SH_W'(b + 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				num_s4[k] <= 32'(num_s3[k] >> sh_c[k]);
				den_s4[k] <= 32'(den_s3[k] >> sh_c[k]);
			end
			ctx_s4.verts  <= verts_s3;
			ctx_s4.tested <= tested_s3;
			ctx_s4.on     <= on_s3;
		end
	end

	assign num_n = num_s4;
	assign den_n = den_s4;
	assign ctx   = ctx_s4;

endmodule
`default_nettype wire

>>> design/tps_div.sv
// Pipelined restoring divider: one quotient bit per stage, t = num*2^30/den.
`timescale 1ns / 1ps
`default_nettype none
module tps_div (
	input  logic                  clk,
	input  logic                  en,
	input  logic [31:0]           num,
	input  logic [31:0]           den,
	output logic [tps_pkg::T_W-1:0] q
);
	import tps_pkg::*;

	logic [31:0]    rem_s [DIV_STEPS];
	logic [31:0]    dvs_s [DIV_STEPS];
	logic [T_W-1:0] quo_s [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [32:0]    rin;
		logic [31:0]    dvs_in;
		logic [T_W-1:0] quo_in;
		logic           ge;

		// first step compares the bare numerator, later ones shift in a zero
		if (k == 0) begin : g_first
			assign rin    = {1'b0, num};
			assign dvs_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rin    = {rem_s[k-1], 1'b0};
			assign dvs_in = dvs_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		assign ge = rin >= {1'b0, dvs_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? 32'(rin - {1'b0, dvs_in}) : 32'(rin);
				dvs_s[k] <= dvs_in;
				quo_s[k] <= quo_in | (ge ? (T_W'(1) << (T_W - 1 - k)) : T_W'(0));
			end
		end
	end

	assign q = quo_s[DIV_STEPS-1];

endmodule
`default_nettype wire

>>> design/tps_merge.sv
// Interpolation, duplicate removal and minimum-length test, seven stages.
`timescale 1ns / 1ps
`default_nettype none
module tps_merge (
	input  logic                  clk,
	input  logic                  en,
	input  tps_pkg::ctx_t         ctx,
	input  logic [tps_pkg::T_W-1:0] t [3],
	input  logic [15:0]           eps,
	output tps_pkg::seg_t         seg,
	output logic                  ok
);
	import tps_pkg::*;

	// coordinate difference within tolerance
	function automatic logic near(logic [31:0] a, logic [31:0] b, logic [15:0] e);
		logic signed [32:0] df;
		logic signed [32:0] es;
		df = $signed({a[31], a}) - $signed({b[31], b});
		es = $signed({17'b0, e});
		return (df <= es) && (df >= -es);
	endfunction

	pt_t                lo_c [3];
	pt_t                hi_c [3];
	logic signed [32:0] delta_c [3][3];
	logic signed [63:0] prod_s1 [3][3];
	ctx_t               ctx_s1;

	pt_t                base_c [3];
	logic signed [63:0] rnd_c [3][3];
	pt_t                cross_c [3];
	pt_t                cross_s2 [3];
	ctx_t               ctx_s2;

	pt_t                cand_c [6];
	logic [5:0]         cval_c;
	logic [5:0][5:0]    same_c;
	pt_t                cand_s3 [6];
	logic [5:0]         cval_s3;
	logic [5:0][5:0]    same_s3;

	logic [5:0]         kept_c;
	logic [2:0]         cnt_c;
	logic               hit_c;
	pt_t                p0_c, p1_c;
	pt_t                p0_s4, p1_s4;
	logic               two_s4;

	logic signed [32:0] dl_c [3];
	logic [32:0]        ad_c [3];
	logic               long_c;
	pt_t                p0_s5, p1_s5;
	logic               two_s5, long_s5;
	logic [15:0]        dd_s5 [3];

	pt_t                p0_s6, p1_s6;
	logic               two_s6, long_s6;
	logic [31:0]        sq_s6 [3];
	logic [31:0]        epsq_s6;

	logic [33:0]        sum_c;
	seg_t               seg_s7;
	logic               ok_s7;

	// stage 1: edge delta times interpolation factor
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			lo_c[k] = vtx(ctx.verts, EDGE_LO[k]);
			hi_c[k] = vtx(ctx.verts, EDGE_HI[k]);
			for (int c = 0; c < 3; c++) begin
				delta_c[k][c] = $signed({hi_c[k][c][31], hi_c[k][c]})
					- $signed({lo_c[k][c][31], lo_c[k][c]});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s1[k][c] <= delta_c[k][c] * $signed({1'b0, t[k]});
				end
			end
			ctx_s1 <= ctx;
		end
	end

	// stage 2: round half up, add to the start vertex
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			base_c[k] = vtx(ctx_s1.verts, EDGE_LO[k]);
			for (int c = 0; c < 3; c++) begin
				rnd_c[k][c]   = (prod_s1[k][c] + 64'sd536870912) >>> 30;
				cross_c[k][c] = base_c[k][c] + rnd_c[k][c][31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cross_s2 <= cross_c;
			ctx_s2   <= ctx_s1;
		end
	end

	// stage 3: six candidate slots, two per edge, and pairwise closeness
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			cand_c[2*k]     = ctx_s2.on[EDGE_LO[k]] ? vtx(ctx_s2.verts, EDGE_LO[k])
				: cross_s2[k];
			cval_c[2*k]     = ctx_s2.tested[k]
				& (ctx_s2.on[EDGE_LO[k]] | ~ctx_s2.on[EDGE_HI[k]]);
			cand_c[2*k+1]   = vtx(ctx_s2.verts, EDGE_HI[k]);
			cval_c[2*k+1]   = ctx_s2.tested[k] & ctx_s2.on[EDGE_HI[k]];
		end
		same_c = '0;
		for (int l = 0; l < 6; l++) begin
			for (int m = l + 1; m < 6; m++) begin
				same_c[l][m] = near(cand_c[l][0], cand_c[m][0], eps)
					&& near(cand_c[l][1], cand_c[m][1], eps)
					&& near(cand_c[l][2], cand_c[m][2], eps);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cand_s3 <= cand_c;
			cval_s3 <= cval_c;
			same_s3 <= same_c;
		end
	end

	// stage 4: keep slots in order unless close to one kept earlier
	always_comb begin
		kept_c = '0;
		cnt_c  = '0;
		hit_c  = 1'b0;
		p0_c   = '0;
		p1_c   = '0;
		for (int m = 0; m < 6; m++) begin
			hit_c = 1'b0;
			for (int l = 0; l < m; l++) begin
				hit_c = hit_c | (kept_c[l] & same_s3[l][m]);
			end
			kept_c[m] = cval_s3[m] & ~hit_c;
			if (kept_c[m]) begin
				if (cnt_c == 3'd0) p0_c = cand_s3[m];
				else if (cnt_c == 3'd1) p1_c = cand_s3[m];
				cnt_c = cnt_c + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s4  <= p0_c;
			p1_s4  <= p1_c;
			two_s4 <= (cnt_c == 3'd2);
		end
	end

	// stage 5: per-axis distance and the coarse length test
	always_comb begin
		long_c = 1'b0;
		for (int c = 0; c < 3; c++) begin
			dl_c[c] = $signed({p1_s4[c][31], p1_s4[c]}) - $signed({p0_s4[c][31], p0_s4[c]});
			ad_c[c] = dl_c[c][32] ? 33'(-dl_c[c]) : 33'(dl_c[c]);
			long_c  = long_c | (ad_c[c] > {17'b0, eps});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s5   <= p0_s4;
			p1_s5   <= p1_s4;
			two_s5  <= two_s4;
			long_s5 <= long_c;
			for (int c = 0; c < 3; c++) dd_s5[c] <= ad_c[c][15:0];
		end
	end

	// stage 6: squares
	always_ff @(posedge clk) begin
		if (en) begin
			p0_s6   <= p0_s5;
			p1_s6   <= p1_s5;
			two_s6  <= two_s5;
			long_s6 <= long_s5;
			for (int c = 0; c < 3; c++) sq_s6[c] <= dd_s5[c] * dd_s5[c];
			epsq_s6 <= eps * eps;
		end
	end

	// stage 7: squared length against epsilon squared, output register
	assign sum_c = {2'b0, sq_s6[0]} + {2'b0, sq_s6[1]} + {2'b0, sq_s6[2]};

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s7.start_x <= p0_s6[0];
			seg_s7.start_y <= p0_s6[1];
			seg_s7.start_z <= p0_s6[2];
			seg_s7.end_x   <= p1_s6[0];
			seg_s7.end_y   <= p1_s6[1];
			seg_s7.end_z   <= p1_s6[2];
			ok_s7          <= two_s6 & (long_s6 | (sum_c > {2'b0, epsq_s6}));
		end
	end

	assign seg = seg_s7;
	assign ok  = ok_s7;

endmodule
`default_nettype wire

>>> design/tps_checker.sv
// Port-level checks for the triangle plane slicer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tps_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          tri_valid,
	input logic          tri_ready,
	input logic          seg_valid,
	input logic          seg_ready,
	input tps_pkg::seg_t seg_data
);
	import tps_pkg::*;

	// a held segment keeps its value
	a_seg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && !seg_ready |=> seg_valid && $stable(seg_data))
		else $error("segment changed while stalled");

	// input is refused while the output is stalled
	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && !seg_ready |-> !tri_ready)
		else $error("triangle taken while output stalled");

	a_free_in: assert property (@(posedge clk) disable iff (!arst_n)
		!seg_valid |-> tri_ready)
		else $error("input blocked with empty output");

	// kept points are never identical
	a_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid |-> (seg_data.start_x != seg_data.end_x)
			|| (seg_data.start_y != seg_data.end_y)
			|| (seg_data.start_z != seg_data.end_z))
		else $error("segment end points coincide");

endmodule

bind triangle_plane_slice tps_checker u_tps_checker (.*);
`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the triangle plane slicer.
`timescale 1ns / 1ps
module testbench;
	import tps_pkg::*;

	logic  clk;
	logic  arst_n;
	logic  cfg_we;
	logic  [2:0] cfg_index;
	logic  [31:0] cfg_data;
	logic  tri_valid;
	logic  tri_ready;
	tri_t  tri_data;
	logic  seg_valid;
	logic  seg_ready;
	seg_t  seg_data;

	triangle_plane_slice dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.tri_valid(tri_valid), .tri_ready(tri_ready), .tri_data(tri_data),
		.seg_valid(seg_valid), .seg_ready(seg_ready), .seg_data(seg_data)
	);

	// plane and tolerance as the predictor sees them
	longint nrm_a, nrm_b, nrm_c, ofs_d, tol;

	seg_t pending_segs[$];
	bit   failed;
	int   snd_pct, rcv_pct;

	typedef struct {
		tri_t verts;
		bit   typed;
		bit   hit;
		seg_t seg;
	} stim_row_t;

	stim_row_t rows[$];

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop for a hung run
	initial begin
		#2ms;
		$display("RESULT: ERROR");
		$finish;
	end

	// predicted segment of one triangle under the current plane; 0 when none
	function automatic bit slice_tri(input tri_t t, output seg_t s);
		longint vx[3][3];
		longint dst[3];
		longint cand[9][3];
		longint pts[6][3];
		int     lo[3];
		int     hi[3];
		longint e, di, dj, dd, df;
		longint unsigned num, den, tq, sq;
		int     n, nc, sh, i, j, k, m, c;
		bit     oni, onj, dup, same, longer;
		lo = '{0, 1, 0};
		hi = '{1, 2, 2};
		vx[0] = '{longint'(t.v0_x), longint'(t.v0_y), longint'(t.v0_z)};
		vx[1] = '{longint'(t.v1_x), longint'(t.v1_y), longint'(t.v1_z)};
		vx[2] = '{longint'(t.v2_x), longint'(t.v2_y), longint'(t.v2_z)};
		s = '0;
		e = tol * 65536;
		for (k = 0; k < 3; k++)
			dst[k] = ((nrm_a * vx[k][0]) >>> 14) + ((nrm_b * vx[k][1]) >>> 14) +
				((nrm_c * vx[k][2]) >>> 14) + ofs_d * 65536;
		// candidate points, edges 01, 12, 02
		nc = 0;
		for (k = 0; k < 3; k++) begin
			i = lo[k];
			j = hi[k];
			di = dst[i];
			dj = dst[j];
			oni = (di < 0 ? -di : di) <= e;
			onj = (dj < 0 ? -dj : dj) <= e;
			if (!((di <= e && dj >= -e) || (di >= -e && dj <= e)))
				continue;
			if (oni || onj) begin
				if (oni) begin
					cand[nc] = vx[i];
					nc++;
				end
				if (onj) begin
					cand[nc] = vx[j];
					nc++;
				end
			end else begin
				num = longint'(di < 0 ? -di : di);
				den = num + longint'(dj < 0 ? -dj : dj);
				sh = 0;
				while ((den >> sh) >= 64'h1_0000_0000) sh++;
				tq = ((num >> sh) << 30) / (den >> sh);
				for (m = 0; m < 3; m++)
					cand[nc][m] = vx[i][m] +
						(((vx[j][m] - vx[i][m]) * longint'(tq) + (64'sd1 <<< 29)) >>> 30);
				nc++;
			end
		end
		// drop points matching an earlier one within tolerance
		n = 0;
		for (c = 0; c < nc; c++) begin
			dup = 0;
			for (k = 0; k < n; k++) begin
				same = 1;
				for (m = 0; m < 3; m++) begin
					df = pts[k][m] - cand[c][m];
					if ((df < 0 ? -df : df) > tol) same = 0;
				end
				if (same) dup = 1;
			end
			if (!dup && n < 6) begin
				pts[n] = cand[c];
				n++;
			end
		end
		if (n != 2)
			return 0;
		longer = 0;
		sq = 0;
		for (m = 0; m < 3; m++) begin
			dd = pts[1][m] - pts[0][m];
			if (dd < 0) dd = -dd;
			if (dd > tol) longer = 1;
			else sq += longint'(dd) * longint'(dd);
		end
		if (!longer && sq <= longint'(tol) * longint'(tol))
			return 0;
		s.start_x = 32'(pts[0][0]);
		s.start_y = 32'(pts[0][1]);
		s.start_z = 32'(pts[0][2]);
		s.end_x   = 32'(pts[1][0]);
		s.end_y   = 32'(pts[1][1]);
		s.end_z   = 32'(pts[1][2]);
		return 1;
	endfunction

	// register write, entered and left at a falling edge
	task automatic set_reg(input cfg_reg_t r, input logic [31:0] v);
		cfg_we = 1'b1;
		cfg_index = r;
		cfg_data = v;
		case (r)
			REG_PLANE_A: nrm_a = longint'($signed(v));
			REG_PLANE_B: nrm_b = longint'($signed(v));
			REG_PLANE_C: nrm_c = longint'($signed(v));
			REG_PLANE_D: ofs_d = longint'($signed(v));
			REG_EPSILON: tol = longint'(v[15:0]);
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_plane(input logic [31:0] a, b, c, d, input logic [15:0] eps);
		while (pending_segs.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
		set_reg(REG_PLANE_A, a);
		set_reg(REG_PLANE_B, b);
		set_reg(REG_PLANE_C, c);
		set_reg(REG_PLANE_D, d);
		set_reg(REG_EPSILON, {16'd0, eps});
	endtask

	// one triangle transaction; expectation either typed or predicted
	task automatic send_tri(input stim_row_t r);
		seg_t s;
		bit   hit;
		while ($urandom_range(99) < snd_pct) begin
			tri_valid = 1'b0;
			@(negedge clk);
		end
		tri_valid = 1'b1;
		tri_data = r.verts;
		do @(posedge clk); while (!tri_ready);
		if (r.typed) begin
			hit = r.hit;
			s = r.seg;
		end else
			hit = slice_tri(r.verts, s);
		if (hit) pending_segs = {pending_segs, s};
		@(negedge clk);
	endtask

	function automatic logic [31:0] rnd_coord(input int unsigned mag);
		return 32'($urandom_range(2 * mag)) - mag;
	endfunction

	// mostly triangles of moderate size near the origin, some noise
	function automatic tri_t rnd_tri();
		tri_t t;
		int unsigned mag;
		int sel;
		sel = $urandom_range(9);
		mag = 1 << $urandom_range(8, 26);
		t = '0;
		if (sel < 2)
			t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom};
		else
			t = {rnd_coord(mag), rnd_coord(mag), rnd_coord(mag),
				rnd_coord(mag), rnd_coord(mag), rnd_coord(mag),
				rnd_coord(mag), rnd_coord(mag), rnd_coord(mag)};
		if (sel == 8) begin
			// near-duplicate vertices
			t.v1_x = t.v0_x + rnd_coord(4);
			t.v1_y = t.v0_y + rnd_coord(4);
			t.v1_z = t.v0_z + rnd_coord(4);
		end else if (sel == 9) begin
			t.v0_x = '0;
			t.v0_y = '0;
			t.v0_z = '0;
		end
		return t;
	endfunction

	// result checker
	always @(posedge clk) begin
		string names[6];
		seg_t  want;
		int    f;
		names = '{"start_x", "start_y", "start_z", "end_x", "end_y", "end_z"};
		if (arst_n && seg_valid && seg_ready) begin
			if (pending_segs.size() == 0) begin
				$error("unexpected segment %h", seg_data);
				failed = 1;
			end else begin
				want = pending_segs.pop_front();
				for (f = 0; f < 6; f++)
					if (want[191-32*f -: 32] !== seg_data[191-32*f -: 32]) begin
						$error("%s: expected %h, got %h", names[f],
							want[191-32*f -: 32], seg_data[191-32*f -: 32]);
						failed = 1;
					end
			end
		end
	end

	// receiver back-pressure
	always @(negedge clk)
		seg_ready <= ($urandom_range(99) >= rcv_pct);

	// stimulus
	initial begin
		stim_row_t r;
		int ph, k;
		failed = 0;
		snd_pct = 0;
		rcv_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tri_valid = 1'b0;
		tri_data = '0;
		nrm_a = 0;
		nrm_b = 0;
		nrm_c = longint'(PLANE_C_RESET);
		ofs_d = 0;
		tol = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed rows under the reset plane z = 0
		r.typed = 1;
		// straddles the plane: two interpolated points
		r.verts = {32'sh0, 32'sh0, -32'sh10000, 32'sh0, 32'sh0, 32'sh10000,
			32'sh20000, 32'sh0, 32'sh10000};
		r.hit = 1;
		r.seg = {32'sh0, 32'sh0, 32'sh0, 32'sh10000, 32'sh0, 32'sh0};
		rows = {rows, r};
		// edge lying on the plane
		r.verts = {32'sh0, 32'sh0, 32'sh0, 32'sh10000, 32'sh0, 32'sh0,
			32'sh0, 32'sh0, 32'sh10000};
		rows = {rows, r};
		// wholly above the plane
		r.verts = {32'sh0, 32'sh0, 32'sh10000, 32'sh10000, 32'sh0, 32'sh10000,
			32'sh0, 32'sh10000, 32'sh10000};
		r.hit = 0;
		r.seg = '0;
		rows = {rows, r};
		// wholly in the plane: three points
		r.verts = {32'sh0, 32'sh0, 32'sh0, 32'sh10000, 32'sh0, 32'sh0,
			32'sh0, 32'sh10000, 32'sh0};
		rows = {rows, r};
		// collapsed to a point on the plane
		r.verts = '0;
		rows = {rows, r};
		// extremes, checked by the predictor
		r.typed = 0;
		r.verts = {9{32'h7fffffff}};
		rows = {rows, r};
		r.verts = {9{32'h80000000}};
		rows = {rows, r};
		r.verts = {32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
			32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000};
		rows = {rows, r};
		r.verts = {32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h7fffffff, 32'h0, 32'hffffffff, 32'h00000001};
		rows = {rows, r};
		// vertex on the plane, opposite edge crossing
		r.verts = {32'sh0, 32'sh0, 32'sh0, 32'sh30000, 32'sh10000, -32'sh8000,
			-32'sh20000, 32'sh50000, 32'sh18000};
		rows = {rows, r};
		// repeated vertex across the plane
		r.verts = {32'sh1234, 32'sh5678, -32'sh10000, 32'sh1234, 32'sh5678, -32'sh10000,
			32'sh1234, 32'sh5678, 32'sh10000};
		rows = {rows, r};
		// tiny crossing segment
		r.verts = {32'sh0, 32'sh0, -32'sh1, 32'sh1, 32'sh0, 32'sh1,
			32'sh0, 32'sh1, 32'sh1};
		rows = {rows, r};
		foreach (rows[k]) send_tri(rows[k]);

		// phases over plane settings and idling patterns
		r.typed = 0;
		for (ph = 0; ph < 8; ph++) begin
			tri_valid = 1'b0;
			case (ph)
				1: set_plane(32'd0, 32'd0, 32'h40000000, 32'h00010000, 16'h0100);
				2: set_plane(32'd644245094, 32'd0, 32'd858993459, 32'hfffe8000, 16'd20);
				3: set_plane(32'hc0000000, 32'h40000000, 32'hc0000000, 32'h7fffffff,
					16'hffff);
				4: set_plane(32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h80000000,
					16'h0000);
				5: set_plane($urandom, $urandom, $urandom, {{12{1'b0}}, 20'($urandom)},
					16'($urandom));
				6: set_plane(32'h40000000, 32'd0, 32'd0, 32'hfffd0000, 16'h0001);
				7: set_plane(32'd0, 32'd0, 32'h40000000, 32'd0, 16'hffff);
				default: ;
			endcase
			case (ph % 4)
				0: begin snd_pct = 0;  rcv_pct = 0;  end
				1: begin snd_pct = 80; rcv_pct = 0;  end
				2: begin snd_pct = 0;  rcv_pct = 80; end
				default: begin snd_pct = 24; rcv_pct = 24; end
			endcase
			for (k = 0; k < 105; k++) begin
				r.verts = rnd_tri();
				send_tri(r);
			end
		end
		tri_valid = 1'b0;

		while (pending_segs.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (!failed)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> files.f
design/tps_pkg.sv
design/tps_dist.sv
design/tps_edge.sv
design/tps_div.sv
design/tps_merge.sv
design/triangle_plane_slice.sv
design/tps_checker.sv
tb/sv/testbench.sv
